### hdl/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Depends on nothing; each macro samples on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property held at every rising edge outside reset.
`define MCBD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcbd assertion failed");
// Implication checked at the same edge.
`define MCBD_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  `MCBD_ASSERT(label, clk, rst_n, (pre) |-> (post))
`endif

### hdl/mcbd_pkg.sv
// Package of the mip chain box downsampler: types, codes and fixed widths.
// Depends on nothing.
`default_nettype none
package mcbd_pkg;
  localparam int NUM_LANES  = 4;
  localparam int LANE_W     = 8;
  localparam int PIX_W      = NUM_LANES * LANE_W;
  localparam int LVL_OUT_W  = 4;
  localparam int POS_W      = 9;
  localparam int SIDE_W     = 4;
  localparam int CHAN_W     = 3;
  localparam int CFG_DATA_W = 4;
  localparam logic [SIDE_W-1:0] SIDE_RST = 4'd10;
  localparam logic [CHAN_W-1:0] CHAN_RST = 3'd4;

  typedef enum logic {
    CFG_SIDE_LOG2 = 1'b0,
    CFG_CHANNELS  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LEVEL,
    SEQ_AVG
  } seq_state_e;

  typedef struct packed {
    logic [LVL_OUT_W-1:0] mip_level;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [PIX_W-1:0]     pix;
    logic                 run_end;
    logic                 chain_done;
  } res_word_t;
endpackage
`default_nettype wire

### hdl/mcbd_if.sv
// Valid/ready channel interfaces for base pixels in and mip pixels out.
// Depends on mcbd_pkg.
`default_nettype none
interface mcbd_pix_if import mcbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] chan_a;
  logic [LANE_W-1:0] chan_b;
  logic [LANE_W-1:0] chan_c;
  logic [LANE_W-1:0] chan_d;
  modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
  modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface mcbd_res_if import mcbd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LVL_OUT_W-1:0] mip_level;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [LANE_W-1:0]    out_a;
  logic [LANE_W-1:0]    out_b;
  logic [LANE_W-1:0]    out_c;
  logic [LANE_W-1:0]    out_d;
  logic                 run_end;
  logic                 chain_done;
  modport source (output valid, mip_level, pos_x, pos_y, out_a, out_b, out_c, out_d,
                  run_end, chain_done, input ready);
  modport sink (input valid, mip_level, pos_x, pos_y, out_a, out_b, out_c, out_d,
                run_end, chain_done, output ready);
endinterface
`default_nettype wire

### hdl/mcbd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mcbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

### hdl/mcbd_lane.sv
// One channel lane: the truncated mean of the four pixels of a 2x2 block.
// Depends on mcbd_pkg.
`default_nettype none
module mcbd_lane import mcbd_pkg::*; (
  input  wire logic [LANE_W-1:0] p_i,
  input  wire logic [LANE_W-1:0] q_i,
  input  wire logic [LANE_W-1:0] r_i,
  input  wire logic [LANE_W-1:0] s_i,
  output logic      [LANE_W-1:0] avg_o
);
  logic [LANE_W+1:0] sum;

  assign sum   = (LANE_W+2)'(p_i) + (LANE_W+2)'(q_i) + (LANE_W+2)'(r_i) + (LANE_W+2)'(s_i);
  assign avg_o = sum[LANE_W+1:2];
endmodule
`default_nettype wire

### hdl/mcbd_fifo.sv
// Small result queue in flip-flops between the level sequencer and the output.
// Depends on mcbd_pkg.
`default_nettype none
module mcbd_fifo import mcbd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire res_word_t wdata_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output res_word_t      rdata_o,
  output logic           empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  res_word_t           mem_q [DEPTH];
  logic [PW-1:0]       wr_q, rd_q;
  logic [$clog2(DEPTH+1)-1:0] cnt_q;

  assign full_o  = (cnt_q == ($clog2(DEPTH+1))'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/mipmap_chain_box_downsampler.sv
// Top level of the mip chain box downsampler: input word buffer, level
// sequencer, row store, channel lanes and result queue.
// Depends on mcbd_pkg, mcbd_if, mcbd_ram, mcbd_lane and mcbd_fifo.
//
// Base pixels enter in raster order and every completed 2x2 block yields one
// pixel of the next level, which is fed on down the chain within the same
// word. The sequencer visits the levels in turn; a level that completes a
// block passes on to the averaging state, which takes the row store's
// registered read data and waits while the result queue is full. A new word
// is taken into the input buffer while the previous one is still being
// worked. Results wait in a four-word queue. Any register write restarts
// the chain.
`default_nettype none
module mipmap_chain_box_downsampler import mcbd_pkg::*; #(
  parameter int MAX_SIDE_LOG2 = 10,
  parameter int MAX_CHANNELS  = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  mcbd_pix_if.sink                   pix_i,
  mcbd_res_if.source                 res_o
);
  localparam int SW    = MAX_SIDE_LOG2;
  localparam int LW    = $clog2(MAX_SIDE_LOG2 + 1);
  localparam int IW    = (MAX_SIDE_LOG2 > 1) ? $clog2(MAX_SIDE_LOG2) : 1;
  localparam int AW    = MAX_SIDE_LOG2 + 1;
  localparam int DEPTH = 2 ** AW;

  logic [SIDE_W-1:0] side_q;
  logic [CHAN_W-1:0] chan_q;
  logic [LW-1:0]     lg;
  logic [CHAN_W-1:0] nch;

  always_comb begin
    if (side_q == '0) begin
      lg = LW'(1);
    end else if (int'(side_q) > MAX_SIDE_LOG2) begin
      lg = LW'(MAX_SIDE_LOG2);
    end else begin
      lg = LW'(side_q);
    end
    if (chan_q == '0) begin
      nch = CHAN_W'(1);
    end else if (int'(chan_q) > MAX_CHANNELS) begin
      nch = CHAN_W'(MAX_CHANNELS);
    end else begin
      nch = chan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RST;
      chan_q <= CHAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SIDE_LOG2: side_q <= SIDE_W'(cfg_data_i);
        CFG_CHANNELS:  chan_q <= CHAN_W'(cfg_data_i);
        default:       side_q <= side_q;
      endcase
    end
  end

  // Input word buffer.
  logic             ibuf_vld_q;
  logic [PIX_W-1:0] ibuf_q;
  logic [PIX_W-1:0] in_pix;
  logic             take;

  always_comb begin
    in_pix = '0;
    if (nch > CHAN_W'(0)) in_pix[7:0]   = pix_i.chan_a;
    if (nch > CHAN_W'(1)) in_pix[15:8]  = pix_i.chan_b;
    if (nch > CHAN_W'(2)) in_pix[23:16] = pix_i.chan_c;
    if (nch > CHAN_W'(3)) in_pix[31:24] = pix_i.chan_d;
  end

  assign pix_i.ready = !ibuf_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ibuf_vld_q <= 1'b0;
    end else if (pix_i.valid && pix_i.ready) begin
      ibuf_vld_q <= 1'b1;
    end else if (take) begin
      ibuf_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      ibuf_q <= in_pix;
    end
  end

  // Level sequencer state.
  seq_state_e       state_q, state_d;
  logic [IW-1:0]    lvl_q, lvl_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic [SW-1:0]    x_q, y_q;
  logic [SW-1:0]    col_q [MAX_SIDE_LOG2];
  logic [SW-1:0]    row_q [MAX_SIDE_LOG2];
  logic [PIX_W-1:0] left_q [MAX_SIDE_LOG2];
  logic [PIX_W-1:0] ul_q [MAX_SIDE_LOG2];
  logic             ul_pend_q;
  logic [IW-1:0]    ul_lvl_q;

  logic [SW:0]      side_w;
  logic [SW-1:0]    mask, x, y;
  logic [AW-1:0]    idx;
  logic [LW-1:0]    next_lvl;
  logic             last;
  logic             pos_upd, left_we, ul_req, save_xy;
  logic             ram_we, ram_re;
  logic [PIX_W-1:0] ram_rdata, avg;
  logic             push, fifo_full, fifo_empty;
  res_word_t        res_w, res_r;
  logic             nb_x, nb_y;

  assign side_w   = (SW+1)'(1) << (lg - LW'(lvl_q));
  assign mask     = side_w[SW-1:0] - 1'b1;
  assign x        = col_q[lvl_q] & mask;
  assign y        = row_q[lvl_q] & mask;
  assign idx      = AW'(DEPTH - (DEPTH >> lvl_q)) + AW'(x);
  assign next_lvl = LW'(lvl_q) + 1'b1;
  assign last     = (next_lvl == lg);
  assign nb_x     = |((x_q >> 1) & SW'(1));
  assign nb_y     = |((y_q >> 1) & SW'(1));

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    pix_d   = pix_q;
    take    = 1'b0;
    pos_upd = 1'b0;
    left_we = 1'b0;
    ul_req  = 1'b0;
    save_xy = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    push    = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (ibuf_vld_q) begin
          take    = 1'b1;
          pix_d   = ibuf_q;
          lvl_d   = '0;
          state_d = SEQ_LEVEL;
        end
      end
      SEQ_LEVEL: begin
        pos_upd = 1'b1;
        if (!y[0] || !x[0]) begin
          if (!y[0]) begin
            ram_we = 1'b1;
          end else begin
            left_we = 1'b1;
            ram_re  = 1'b1;
            ul_req  = 1'b1;
          end
          if (ibuf_vld_q) begin
            take  = 1'b1;
            pix_d = ibuf_q;
            lvl_d = '0;
          end else begin
            state_d = SEQ_IDLE;
          end
        end else begin
          ram_re  = 1'b1;
          save_xy = 1'b1;
          state_d = SEQ_AVG;
        end
      end
      SEQ_AVG: begin
        if (!fifo_full) begin
          push = 1'b1;
          if (!last) begin
            pix_d   = avg;
            lvl_d   = lvl_q + 1'b1;
            state_d = SEQ_LEVEL;
          end else if (ibuf_vld_q) begin
            take    = 1'b1;
            pix_d   = ibuf_q;
            lvl_d   = '0;
            state_d = SEQ_LEVEL;
          end else begin
            state_d = SEQ_IDLE;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      lvl_q     <= '0;
      ul_pend_q <= 1'b0;
      ul_lvl_q  <= '0;
      for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
        col_q[k] <= '0;
        row_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      ul_pend_q <= ul_req;
      if (ul_req) begin
        ul_lvl_q <= lvl_q;
      end
      if (cfg_we_i) begin
        for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
          col_q[k] <= '0;
          row_q[k] <= '0;
        end
      end else if (pos_upd) begin
        if (x == mask) begin
          col_q[lvl_q] <= '0;
          row_q[lvl_q] <= (y == mask) ? '0 : y + 1'b1;
        end else begin
          col_q[lvl_q] <= x + 1'b1;
          row_q[lvl_q] <= y;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    if (save_xy) begin
      x_q <= x;
      y_q <= y;
    end
    if (left_we) begin
      left_q[lvl_q] <= pix_q;
    end
    if (ul_pend_q) begin
      ul_q[ul_lvl_q] <= ram_rdata;
    end
  end

  mcbd_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx),
    .wdata_i(pix_q),
    .re_i   (ram_re),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    mcbd_lane u_lane (
      .p_i  (ul_q[lvl_q][c*LANE_W +: LANE_W]),
      .q_i  (ram_rdata[c*LANE_W +: LANE_W]),
      .r_i  (left_q[lvl_q][c*LANE_W +: LANE_W]),
      .s_i  (pix_q[c*LANE_W +: LANE_W]),
      .avg_o(avg[c*LANE_W +: LANE_W])
    );
  end

  always_comb begin
    res_w.mip_level  = LVL_OUT_W'(next_lvl);
    res_w.pos_x      = POS_W'(x_q >> 1);
    res_w.pos_y      = POS_W'(y_q >> 1);
    res_w.pix        = avg;
    res_w.run_end    = last || !(nb_x && nb_y);
    res_w.chain_done = last;
  end

  mcbd_fifo #(
    .DEPTH(4)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(res_w),
    .full_o (fifo_full),
    .pop_i  (res_o.valid && res_o.ready),
    .rdata_o(res_r),
    .empty_o(fifo_empty)
  );

  assign res_o.valid      = !fifo_empty;
  assign res_o.mip_level  = res_r.mip_level;
  assign res_o.pos_x      = res_r.pos_x;
  assign res_o.pos_y      = res_r.pos_y;
  assign res_o.out_a      = res_r.pix[7:0];
  assign res_o.out_b      = res_r.pix[15:8];
  assign res_o.out_c      = res_r.pix[23:16];
  assign res_o.out_d      = res_r.pix[31:24];
  assign res_o.run_end    = res_r.run_end;
  assign res_o.chain_done = res_r.chain_done;
endmodule
`default_nettype wire

### hdl/mcbd_checker.sv
// Port-level checks on the result channel of the downsampler, and the bind
// that attaches them to the top level. Depends on mcbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mcbd_checker import mcbd_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 res_valid,
  input wire logic                 res_ready,
  input wire logic [LVL_OUT_W-1:0] mip_level,
  input wire logic [POS_W-1:0]     pos_x,
  input wire logic [POS_W-1:0]     pos_y,
  input wire logic                 run_end,
  input wire logic                 chain_done
);
  `MCBD_ASSERT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready |=> res_valid)
  `MCBD_ASSERT_IMPL(a_done_ends_run, clk_i, rst_ni, res_valid && chain_done, run_end)
  `MCBD_ASSERT_IMPL(a_done_origin, clk_i, rst_ni, res_valid && chain_done, pos_x == '0 && pos_y == '0)
  `MCBD_ASSERT_IMPL(a_level_nonzero, clk_i, rst_ni, res_valid, mip_level != '0)
endmodule

bind mipmap_chain_box_downsampler mcbd_checker u_mcbd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .mip_level (res_o.mip_level),
  .pos_x     (res_o.pos_x),
  .pos_y     (res_o.pos_y),
  .run_end   (res_o.run_end),
  .chain_done(res_o.chain_done)
);
`default_nettype wire
